[sv/pad_pkg.sv]
// Shared types, constants and helpers for the two-channel phase dimmer.
// No dependencies; used by pad_core and phase_angle_dimmer_two_channel_top.
package pad_pkg;

  // Event kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_ZC   = 2'd1;
  localparam logic [1:0] KIND_BUS  = 2'd2;

  // Bus slave status codes
  localparam logic [7:0] ST_ADDRESSED = 8'h60;
  localparam logic [7:0] ST_DATA      = 8'h80;
  localparam logic [7:0] ST_STOP      = 8'hA0;

  // Phase tracking
  localparam logic [7:0] LOCK_TARGET   = 8'd61;
  localparam logic [7:0] ERR_UP_LOW    = 8'd200;
  localparam logic [7:0] ERR_UP_HIGH   = 8'd253;
  localparam logic [7:0] ERR_DOWN_LOW  = 8'd3;
  localparam logic [7:0] ERR_DOWN_HIGH = 8'd50;
  localparam logic [7:0] PRESCALE_TOP  = 8'hFF;

  // Reset values
  localparam logic [7:0] RELOAD_RESET     = 8'h70;
  localparam logic [7:0] ZERO_POINT_RESET = 8'd47;

  // Configuration register indexes
  localparam logic CFG_LEAD_EDGE  = 1'b0;
  localparam logic CFG_ZERO_POINT = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] bus_status;
    logic [7:0] bus_data;
  } item_t;

  typedef struct packed {
    logic       lead_edge;
    logic [7:0] zero_point;
  } cfg_t;

  typedef struct packed {
    logic [1:0] drive;
    logic [7:0] reload;
    logic [7:0] phase_error;
  } res_t;

  // Pin level for one channel: 0 turns the triac on
  function automatic logic drive_for(input logic [7:0] phase, input logic [7:0] level,
                                     input logic lead_edge);
    logic in_window;
    in_window = (phase <= level);
    if (!lead_edge) begin
      drive_for = (in_window && (level != 8'd0)) ? 1'b0 : 1'b1;
    end else begin
      drive_for = (in_window || (level == 8'd0)) ? 1'b1 : 1'b0;
    end
  endfunction

endpackage

[sv/phase_angle_dimmer_two_channel_top.sv]
// Two-channel phase dimmer top: input register, dimmer core, result register.
// A beat accepted into the input register is processed by the core and held in the result register, which drives out_*.
// Throughput: one beat per cycle while out_ready holds; the input stage refills while a result waits.
// Reset (rst_n low, synchronous): stages empty, config to trailing edge and
// zero point 47, prescaler and reload 0x70, all other core state zero.
module phase_angle_dimmer_two_channel_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_bus_status,
  input  logic [7:0] in_bus_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_channel_one_drive,
  output logic       out_channel_two_drive,
  output logic [7:0] out_reload_value,
  output logic [7:0] out_phase_error,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic           s1_valid_r;
  pad_pkg::item_t s1_item_r;
  logic           s1_fire;
  logic           out_valid_r;
  pad_pkg::res_t  out_res_r;
  pad_pkg::res_t  res_nxt;
  pad_pkg::res_t  core_cur;
  pad_pkg::cfg_t  cfg_r;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lead_edge  <= 1'b0;
      cfg_r.zero_point <= pad_pkg::ZERO_POINT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pad_pkg::CFG_LEAD_EDGE:  cfg_r.lead_edge  <= cfg_data[0];
        pad_pkg::CFG_ZERO_POINT: cfg_r.zero_point <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= '{kind: in_kind, bus_status: in_bus_status, bus_data: in_bus_data};
    end
  end

  pad_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .res_nxt (res_nxt),
    .cur     (core_cur)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_channel_one_drive = out_res_r.drive[0];
  assign out_channel_two_drive = out_res_r.drive[1];
  assign out_reload_value      = out_res_r.reload;
  assign out_phase_error       = out_res_r.phase_error;

  // Only zero crossings retune the reload value
  a_reload_zc_only: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_item_r.kind != pad_pkg::KIND_ZC) |-> res_nxt.reload == core_cur.reload)
    else $error("reload changed on a non zero-crossing beat");

  // Only ticks move the drives
  a_drive_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_item_r.kind != pad_pkg::KIND_TICK) |-> res_nxt.drive == core_cur.drive)
    else $error("drives changed on a non tick beat");

  // A processed beat always lands in the result register
  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r && (out_res_r == $past(res_nxt)))
    else $error("processed beat not presented");

  // A stalled input stage keeps its beat
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage lost a stalled beat");

endmodule

[sv/pad_core.sv]
// Dimmer state: prescaler, phase counter, reload tracking, bus levels, drives.
// Depends on pad_pkg. Updates state and presents the next result in one pass.
module pad_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  pad_pkg::item_t item,
  input  pad_pkg::cfg_t  cfg,
  output pad_pkg::res_t  res_nxt,
  output pad_pkg::res_t  cur
);

  logic [7:0] prescale_r, prescale_nxt;
  logic [7:0] reload_r, reload_nxt;
  logic [7:0] phase_r, phase_nxt;
  logic [7:0] error_r, error_nxt;
  logic [7:0] byte_idx_r, byte_idx_nxt;
  logic [7:0] level_r [2];
  logic [7:0] level_nxt [2];
  logic [1:0] drive_r, drive_nxt;
  logic [7:0] err;

  // Next-state logic for one beat
  always_comb begin
    prescale_nxt = prescale_r;
    reload_nxt   = reload_r;
    phase_nxt    = phase_r;
    error_nxt    = error_r;
    byte_idx_nxt = byte_idx_r;
    level_nxt    = level_r;
    drive_nxt    = drive_r;
    err          = phase_r - pad_pkg::LOCK_TARGET;
    case (item.kind)
      pad_pkg::KIND_TICK: begin
        if (prescale_r == pad_pkg::PRESCALE_TOP) begin
          prescale_nxt = reload_r;
          phase_nxt    = phase_r + 8'd1;
          drive_nxt    = {pad_pkg::drive_for(phase_nxt, level_r[1], cfg.lead_edge),
                          pad_pkg::drive_for(phase_nxt, level_r[0], cfg.lead_edge)};
        end else begin
          prescale_nxt = prescale_r + 8'd1;
        end
      end
      pad_pkg::KIND_ZC: begin
        error_nxt = err;
        if (err inside {[pad_pkg::ERR_UP_LOW + 8'd1 : pad_pkg::ERR_UP_HIGH - 8'd1]}) begin
          reload_nxt = reload_r + 8'd1;
        end else if (err inside {[pad_pkg::ERR_DOWN_LOW : pad_pkg::ERR_DOWN_HIGH]}) begin
          reload_nxt = reload_r - 8'd1;
        end
        phase_nxt = cfg.zero_point;
      end
      pad_pkg::KIND_BUS: begin
        case (item.bus_status)
          pad_pkg::ST_ADDRESSED, pad_pkg::ST_STOP: byte_idx_nxt = 8'd0;
          pad_pkg::ST_DATA:                        byte_idx_nxt = byte_idx_r + 8'd1;
          default:                                 byte_idx_nxt = byte_idx_r;
        endcase
        // bytes 2 and 3 carry the channel levels
        if (byte_idx_nxt == 8'd2 || byte_idx_nxt == 8'd3) begin
          level_nxt[byte_idx_nxt[0]] = cfg.lead_edge ? (8'd0 - item.bus_data)
                                                     : item.bus_data;
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= pad_pkg::RELOAD_RESET;
      reload_r   <= pad_pkg::RELOAD_RESET;
      phase_r    <= 8'd0;
      error_r    <= 8'd0;
      byte_idx_r <= 8'd0;
      level_r[0] <= 8'd0;
      level_r[1] <= 8'd0;
      drive_r    <= 2'b00;
    end else if (fire) begin
      prescale_r <= prescale_nxt;
      reload_r   <= reload_nxt;
      phase_r    <= phase_nxt;
      error_r    <= error_nxt;
      byte_idx_r <= byte_idx_nxt;
      level_r    <= level_nxt;
      drive_r    <= drive_nxt;
    end
  end

  assign res_nxt = '{drive: drive_nxt, reload: reload_nxt, phase_error: error_nxt};
  assign cur     = '{drive: drive_r, reload: reload_r, phase_error: error_r};

endmodule
